FILE: design/rzml_pkg.sv
// Shared types, constants and helpers for the ring zone motion lighting block.
package rzml_pkg;

  localparam int ZONES_DEF  = 12;
  localparam int SENSOR_W   = 12;
  localparam int MODE_W     = 2;
  localparam int TIMEOUT_W  = 16;
  localparam int LEVEL_W    = 7;
  localparam int INDEX_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 7'd100;

  localparam logic [MODE_W-1:0] MODE_INIT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ACTION = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DEINIT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL2  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL3  = 2'd3;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd200;
  localparam logic [LEVEL_W-1:0]   LEVEL1_RST  = 7'd50;
  localparam logic [LEVEL_W-1:0]   LEVEL2_RST  = 7'd25;
  localparam logic [LEVEL_W-1:0]   LEVEL3_RST  = 7'd10;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [SENSOR_W-1:0] sensor_bits;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] zone_index;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] d1;
    logic [LEVEL_W-1:0] d2;
    logic [LEVEL_W-1:0] d3;
  } lvl_cfg_t;

  // controls broadcast from the sequencer to every cell
  typedef struct packed {
    logic clear;
    logic start;
    logic tick;
    logic load;
    logic zero;
    logic shift;
  } ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_TICK,
    ST_EMIT
  } state_t;

  function automatic logic [LEVEL_W-1:0] cap_level(input logic [LEVEL_W-1:0] v);
    return (v > LEVEL_FULL) ? LEVEL_FULL : v;
  endfunction

endpackage

FILE: design/rzml_cell.sv
// One ring zone: sensor history, active flag, countdown and level shift stage.
module rzml_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rzml_pkg::ctl_t                ctl,
  input  logic                          tok_in,
  input  logic                          samp_in,
  input  logic                          clr_l,
  input  logic                          clr_r,
  input  logic                          near1,
  input  logic                          near2,
  input  logic                          near3,
  input  logic [rzml_pkg::LEVEL_W-1:0]  lvl_in,
  input  logic [rzml_pkg::TIMEOUT_W-1:0] timeout,
  input  rzml_pkg::lvl_cfg_t            lvl_cfg,
  output logic                          tok,
  output logic                          act,
  output logic                          rise_evt,
  output logic [rzml_pkg::LEVEL_W-1:0]  lvl
);
  import rzml_pkg::*;

  logic                 tok_r;
  logic                 samp_r, samp_nxt;
  logic                 prev_r, prev_nxt;
  logic                 act_r, act_nxt;
  logic [TIMEOUT_W-1:0] cd_r, cd_nxt;
  logic [LEVEL_W-1:0]   lvl_r, lvl_nxt;
  logic                 rise, fall;
  logic [LEVEL_W-1:0]   lvl_calc;

  assign rise = tok_r & samp_r & ~prev_r;
  assign fall = tok_r & ~samp_r & prev_r;

  always_comb begin
    if (act_r) begin
      lvl_calc = LEVEL_FULL;
    end else if (near1) begin
      lvl_calc = cap_level(lvl_cfg.d1);
    end else if (near2) begin
      lvl_calc = cap_level(lvl_cfg.d2);
    end else if (near3) begin
      lvl_calc = cap_level(lvl_cfg.d3);
    end else begin
      lvl_calc = '0;
    end
  end

  always_comb begin
    samp_nxt = ctl.start ? samp_in : samp_r;
    prev_nxt = prev_r;
    act_nxt  = act_r;
    cd_nxt   = cd_r;
    if (ctl.clear) begin
      prev_nxt = 1'b0;
      act_nxt  = 1'b0;
      cd_nxt   = '0;
    end else if (ctl.tick) begin
      if (cd_r != '0) begin
        if (cd_r == TIMEOUT_W'(1)) begin
          act_nxt = 1'b0;
        end
        cd_nxt = cd_r - TIMEOUT_W'(1);
      end
    end else begin
      if (tok_r) begin
        prev_nxt = samp_r;
      end
      if (rise) begin
        act_nxt = 1'b1;
      end else if (clr_l | clr_r) begin
        act_nxt = 1'b0;
      end
      if (fall && act_r) begin
        cd_nxt = timeout;
      end
    end
    if (ctl.load) begin
      lvl_nxt = ctl.zero ? '0 : lvl_calc;
    end else if (ctl.shift) begin
      lvl_nxt = lvl_in;
    end else begin
      lvl_nxt = lvl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= 1'b0;
      prev_r <= 1'b0;
      act_r  <= 1'b0;
      cd_r   <= '0;
    end else begin
      tok_r  <= tok_in;
      prev_r <= prev_nxt;
      act_r  <= act_nxt;
      cd_r   <= cd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samp_r <= samp_nxt;
    lvl_r  <= lvl_nxt;
  end

  assign tok      = tok_r;
  assign act      = act_r;
  assign rise_evt = rise;
  assign lvl      = lvl_r;

endmodule

FILE: design/rzml_ctrl.sv
// Sequencer: mode decode, enable flag, zone walk and result emission counter.
module rzml_ctrl #(
  parameter int ZONES = rzml_pkg::ZONES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [rzml_pkg::MODE_W-1:0]  in_mode,
  output logic                         in_stall,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [$clog2(ZONES)-1:0]     cnt,
  output rzml_pkg::ctl_t               ctl
);
  import rzml_pkg::*;

  localparam int CW = $clog2(ZONES);
  localparam logic [CW-1:0] LAST_IDX = CW'(ZONES - 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          en_r, en_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    en_nxt    = en_r;
    ctl       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_mode)
            MODE_INIT: begin
              ctl.clear = 1'b1;
              en_nxt    = 1'b1;
            end
            MODE_CHECK: begin
              if (en_r) begin
                ctl.start = 1'b1;
                cnt_nxt   = '0;
                state_nxt = ST_WALK;
              end
            end
            MODE_ACTION: begin
              if (en_r) begin
                ctl.load  = 1'b1;
                cnt_nxt   = '0;
                state_nxt = ST_EMIT;
              end
            end
            MODE_DEINIT: begin
              en_nxt    = 1'b0;
              ctl.load  = 1'b1;
              ctl.zero  = 1'b1;
              cnt_nxt   = '0;
              state_nxt = ST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_TICK;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_TICK: begin
        ctl.tick  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          ctl.shift = 1'b1;
          if (cnt_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      en_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      en_r    <= en_nxt;
    end
  end

  assign cnt = cnt_r;

  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (cnt_r <= LAST_IDX))
    else $error("zone walk index out of range");

  a_check_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && in_mode == MODE_CHECK && en_r)
    |=> (state_r == ST_WALK && cnt_r == '0))
    else $error("check transaction did not start the walk at zone zero");

  a_tick_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TICK) |-> ($past(state_r) == ST_WALK))
    else $error("countdown tick without a completed walk");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !out_stall && cnt_r == LAST_IDX) |=> (state_r == ST_IDLE))
    else $error("emission did not end after the final zone");

endmodule

FILE: design/ring_zone_motion_lighting_unit.sv
// Top level of the ring zone motion lighting block: config registers and cell ring.
//
// Input channel (in_valid / in_stall / in_data): one transaction carries a mode
// and a sensor sample. Init clears the zone state and enables the block. Check
// walks the ring one zone per cycle, passing a token from cell to cell, then
// applies the countdown tick. Check and action are ignored while disabled.
// Action and deinit load every cell's level at once and shift the chain toward
// zone zero, one result transaction per cycle while out_stall is low on the
// output channel (out_valid / out_stall / out_data), ZONES results, last set
// on the final one. in_stall is high while a check (its walk or countdown
// tick) or an emission is in progress.
// A stalled output holds its result and freezes the level chain.
// Config (cfg_we / cfg_idx / cfg_data) writes one register per cycle, no wait;
// write only while idle.
// Reset (rst_n low, synchronous): block disabled, zone state cleared, config
// registers back to their defaults.
module ring_zone_motion_lighting_unit #(
  parameter int ZONES = rzml_pkg::ZONES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rzml_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rzml_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [rzml_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rzml_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rzml_pkg::*;

  localparam int CW = $clog2(ZONES);
  localparam logic [CW-1:0] LAST_IDX = CW'(ZONES - 1);

  logic [TIMEOUT_W-1:0] timeout_r;
  lvl_cfg_t             lvl_cfg_r;

  ctl_t                 ctl;
  logic [CW-1:0]        cnt;
  logic [ZONES-1:0]     tok_w, act_w, rise_w;
  logic [LEVEL_W-1:0]   lvl_w [ZONES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    <= TIMEOUT_RST;
      lvl_cfg_r.d1 <= LEVEL1_RST;
      lvl_cfg_r.d2 <= LEVEL2_RST;
      lvl_cfg_r.d3 <= LEVEL3_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TIMEOUT: timeout_r    <= cfg_data;
        CFG_LEVEL1:  lvl_cfg_r.d1 <= cfg_data[LEVEL_W-1:0];
        CFG_LEVEL2:  lvl_cfg_r.d2 <= cfg_data[LEVEL_W-1:0];
        CFG_LEVEL3:  lvl_cfg_r.d3 <= cfg_data[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rzml_ctrl #(
    .ZONES(ZONES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cnt      (cnt),
    .ctl      (ctl)
  );

  for (genvar k = 0; k < ZONES; k++) begin : g_cell
    localparam int L1 = (k + ZONES - 1) % ZONES;
    localparam int L2 = (k + ZONES - 2) % ZONES;
    localparam int L3 = (k + ZONES - 3) % ZONES;
    localparam int R1 = (k + 1) % ZONES;
    localparam int R2 = (k + 2) % ZONES;
    localparam int R3 = (k + 3) % ZONES;

    logic               tok_in;
    logic               samp_in;
    logic [LEVEL_W-1:0] lvl_in;

    if (k == 0) begin : g_head
      assign tok_in = ctl.start;
    end else begin : g_body
      assign tok_in = tok_w[k-1];
    end

    if (k < SENSOR_W) begin : g_sense
      assign samp_in = in_data.sensor_bits[k];
    end else begin : g_nosense
      assign samp_in = 1'b0;
    end

    if (k == ZONES - 1) begin : g_tail
      assign lvl_in = '0;
    end else begin : g_link
      assign lvl_in = lvl_w[k+1];
    end

    rzml_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .tok_in  (tok_in),
      .samp_in (samp_in),
      .clr_l   (rise_w[L1]),
      .clr_r   (rise_w[R1]),
      .near1   (act_w[L1] | act_w[R1]),
      .near2   (act_w[L2] | act_w[R2]),
      .near3   (act_w[L3] | act_w[R3]),
      .lvl_in  (lvl_in),
      .timeout (timeout_r),
      .lvl_cfg (lvl_cfg_r),
      .tok     (tok_w[k]),
      .act     (act_w[k]),
      .rise_evt(rise_w[k]),
      .lvl     (lvl_w[k])
    );
  end

  assign out_data.zone_index = INDEX_W'(cnt);
  assign out_data.level      = lvl_w[0];
  assign out_data.last       = (cnt == LAST_IDX);

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_w))
    else $error("more than one zone holds the walk token");

  a_token_at_index: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_w != '0) |-> tok_w[cnt])
    else $error("walk token not at the sequencer zone index");

  a_rise_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(rise_w))
    else $error("more than one rising zone in one cycle");

endmodule

FILE: test/rzml_light_checker.sv
// Checker for the ring zone motion lighting block: predicts zone levels and compares results.
module rzml_light_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  rzml_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  rzml_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [rzml_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rzml_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatch_count,
  output int                              lights_due
);
  import rzml_pkg::*;

  localparam int ZONES = ZONES_DEF;

  logic                 enabled;
  logic [ZONES-1:0]     prev_sensors;
  logic [ZONES-1:0]     active;
  logic [TIMEOUT_W-1:0] countdown [ZONES];
  logic [TIMEOUT_W-1:0] timeout;
  logic [LEVEL_W-1:0]   dist_level [1:3];
  out_item_t            light_queue [$];

  function automatic int ring(int z, int off);
    return (z + off + ZONES) % ZONES;
  endfunction

  task automatic clear_zones();
    prev_sensors = '0;
    active = '0;
    foreach (countdown[k]) countdown[k] = '0;
  endtask

  task automatic take_sample(logic [ZONES-1:0] s);
    for (int k = 0; k < ZONES; k++) begin
      if (s[k] != prev_sensors[k]) begin
        if (s[k]) begin
          active[k] = 1'b1;
          active[ring(k, -1)] = 1'b0;
          active[ring(k, 1)] = 1'b0;
        end else if (active[k]) begin
          countdown[k] = timeout;
        end
        prev_sensors[k] = s[k];
      end
    end
    for (int k = 0; k < ZONES; k++) begin
      if (countdown[k] != '0) begin
        if (countdown[k] == 1) active[k] = 1'b0;
        countdown[k] = countdown[k] - 1'b1;
      end
    end
  endtask

  function automatic logic [LEVEL_W-1:0] zone_light(int z);
    int d;
    if (active[z]) return LEVEL_FULL;
    for (d = 1; d <= 3; d++) begin
      if (active[ring(z, -d)] || active[ring(z, d)])
        return (dist_level[d] > LEVEL_FULL) ? LEVEL_FULL : dist_level[d];
    end
    return '0;
  endfunction

  task automatic queue_lights(bit dark);
    out_item_t item;
    for (int z = 0; z < ZONES; z++) begin
      item.zone_index = z[INDEX_W-1:0];
      item.level = dark ? '0 : zone_light(z);
      item.last = (z == ZONES - 1);
      light_queue.push_back(item);
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      enabled = 1'b0;
      clear_zones();
      timeout = TIMEOUT_RST;
      dist_level[1] = LEVEL1_RST;
      dist_level[2] = LEVEL2_RST;
      dist_level[3] = LEVEL3_RST;
      light_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (light_queue.size() == 0) begin
          $display("%0t: unexpected light transaction zone %0d level %0d last %0b",
                   $time, out_data.zone_index, out_data.level, out_data.last);
          mismatch_count++;
        end else begin
          want = light_queue.pop_front();
          if (out_data.zone_index !== want.zone_index || out_data.level !== want.level ||
              out_data.last !== want.last) begin
            $display("%0t: expected zone %0d level %0d last %0b, got zone %0d level %0d last %0b",
                     $time, want.zone_index, want.level, want.last,
                     out_data.zone_index, out_data.level, out_data.last);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_TIMEOUT: timeout = cfg_data[TIMEOUT_W-1:0];
          CFG_LEVEL1:  dist_level[1] = cfg_data[LEVEL_W-1:0];
          CFG_LEVEL2:  dist_level[2] = cfg_data[LEVEL_W-1:0];
          CFG_LEVEL3:  dist_level[3] = cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (in_data.mode)
          MODE_INIT: begin
            clear_zones();
            enabled = 1'b1;
          end
          MODE_CHECK:  if (enabled) take_sample(in_data.sensor_bits);
          MODE_ACTION: if (enabled) queue_lights(1'b0);
          MODE_DEINIT: begin
            enabled = 1'b0;
            queue_lights(1'b1);
          end
          default: ;
        endcase
      end
    end
    lights_due = light_queue.size();
  end

endmodule

FILE: test/tb_top.sv
// Testbench top for the ring zone motion lighting block: clock, reset, stimulus and verdict.
module tb_top;
  import rzml_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 20;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int                    mismatches;
  int                    lights_due;
  int                    idle_cycles;
  int                    burst_left;
  bit                    hold_req;
  bit                    block_on;
  logic [SENSOR_W-1:0]   last_sample;

  ring_zone_motion_lighting_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  rzml_light_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatches),
    .lights_due     (lights_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stall_gen
    int seg_left;
    int style;
    out_stall = 1'b0;
    seg_left = 0;
    style = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          style = $urandom_range(0, 3);
          seg_left = $urandom_range(10, 60);
        end
        seg_left--;
        case (style)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= ($urandom_range(0, 7) == 0);
          default: out_stall <= seg_left[2];
        endcase
      end
    end
  end

  task automatic offer(input logic [MODE_W-1:0] m, input logic [SENSOR_W-1:0] bits);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
    in_valid <= 1'b1;
    in_data <= in_item_t'{mode: m, sensor_bits: bits};
    do @(posedge clk); while (in_stall);
    burst_left--;
    case (m)
      MODE_INIT: begin
        block_on = 1'b1;
        last_sample = '0;
      end
      MODE_DEINIT: block_on = 1'b0;
      MODE_CHECK:  if (block_on) last_sample = bits;
      default: ;
    endcase
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (lights_due != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] t, input logic [CFG_DATA_W-1:0] l1,
                          input logic [CFG_DATA_W-1:0] l2, input logic [CFG_DATA_W-1:0] l3);
    write_reg(CFG_TIMEOUT, t);
    write_reg(CFG_LEVEL1, l1);
    write_reg(CFG_LEVEL2, l2);
    write_reg(CFG_LEVEL3, l3);
  endtask

  task automatic run_random(input int count, input bit with_hold);
    int n;
    int r;
    logic [MODE_W-1:0] m;
    logic [SENSOR_W-1:0] s;
    logic [SENSOR_W-1:0] flips;
    n = 0;
    offer(MODE_INIT, SENSOR_W'($urandom));
    while (n < count) begin
      r = $urandom_range(0, 99);
      if (!block_on && $urandom_range(0, 4) != 0) m = MODE_INIT;
      else if (r < 4) m = MODE_INIT;
      else if (r < 9) m = MODE_DEINIT;
      else if (r < 40) m = MODE_ACTION;
      else m = MODE_CHECK;
      s = SENSOR_W'($urandom);
      if (m == MODE_CHECK && $urandom_range(0, 4) != 0) begin
        flips = '0;
        repeat ($urandom_range(1, 3)) flips[$urandom_range(0, SENSOR_W - 1)] = 1'b1;
        s = last_sample ^ flips;
      end
      if (block_on || m == MODE_INIT || m == MODE_DEINIT) n++;
      if (with_hold && n == 15) hold_req = 1'b1;
      offer(m, s);
    end
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    burst_left = 0;
    block_on = 1'b0;
    last_sample = '0;
    hold_req = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // disabled block: check and action ignored, deinit still emits
    offer(MODE_CHECK, 12'hFFF);
    offer(MODE_ACTION, 12'h000);
    offer(MODE_DEINIT, 12'hFFF);
    offer(MODE_INIT, 12'hFFF);
    offer(MODE_ACTION, 12'h000);
    offer(MODE_CHECK, 12'h001);
    offer(MODE_ACTION, 12'h000);
    offer(MODE_CHECK, 12'h003);
    offer(MODE_CHECK, 12'h000);
    offer(MODE_ACTION, 12'h000);
    // wrap: zones 0 and 11 rise together
    offer(MODE_CHECK, 12'h801);
    offer(MODE_ACTION, 12'h000);
    offer(MODE_CHECK, 12'hFFF);
    offer(MODE_ACTION, 12'h000);
    offer(MODE_CHECK, 12'h000);
    offer(MODE_CHECK, 12'hAAA);
    offer(MODE_CHECK, 12'h555);
    offer(MODE_ACTION, 12'h000);
    offer(MODE_INIT, 12'h555);
    offer(MODE_ACTION, 12'h000);
    offer(MODE_DEINIT, 12'h000);
    offer(MODE_ACTION, 12'h000);
    offer(MODE_CHECK, 12'h0F0);
    offer(MODE_INIT, 12'h000);
    offer(MODE_ACTION, 12'hFFF);
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_regs(16'd1, 16'd0, 16'd100, 16'd127);
        1: set_regs(16'd0, 16'd100, 16'd0, 16'd101);
        2: set_regs(16'hFFFF, CFG_DATA_W'($urandom_range(0, 127)),
                    CFG_DATA_W'($urandom_range(0, 127)),
                    CFG_DATA_W'($urandom_range(0, 127)));
        default: set_regs(CFG_DATA_W'($urandom_range(1, 6)),
                          CFG_DATA_W'($urandom_range(0, 127)),
                          CFG_DATA_W'($urandom_range(0, 127)),
                          CFG_DATA_W'($urandom_range(0, 127)));
      endcase
      run_random(40, p == 1);
      drain();
    end

    if (mismatches == 0 && lights_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
